// ===== rtl/bld_pkg.sv =====
// ----------------------------------------------------------------------------
// bld_pkg
// Types and constants shared by the bounded deque cell chain.
// ----------------------------------------------------------------------------
package bld_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int LEN_W      = $clog2(DEPTH + 1);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [LEN_W-1:0]      len_t;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_REM_FRONT = 3'd2,
    ACT_REM_BACK  = 3'd3,
    ACT_REM_VALUE = 3'd4,
    ACT_DUMP      = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_FROM_HEAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     valid;
  } cell_ctrl_t;

endpackage

// ===== rtl/bld_if.sv =====
// ----------------------------------------------------------------------------
// bld_req_if / bld_rsp_if
// Valid/ready channels for deque requests and responses.
// ----------------------------------------------------------------------------
interface bld_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

interface bld_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] entry;
  logic [4:0]         length;
  logic               last;

  modport source (output valid, status, entry, length, last, input ready);
  modport sink   (input valid, status, entry, length, last, output ready);
endinterface

// ===== rtl/bld_cell.sv =====
// ----------------------------------------------------------------------------
// bld_cell
// One storage cell of the deque chain with its match and search link.
// ----------------------------------------------------------------------------
module bld_cell (
  input  logic               clk,
  input  bld_pkg::cell_ctrl_t ctrl,
  input  bld_pkg::data_t     key,
  input  bld_pkg::data_t     left,
  input  bld_pkg::data_t     right,
  input  bld_pkg::data_t     head,
  input  logic               seen_in,
  output bld_pkg::data_t     data,
  output logic               seen_out
);
  import bld_pkg::*;

  // first match anywhere at or before this cell
  assign seen_out = seen_in | (ctrl.valid & (data == key));

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      CELL_HOLD:       data <= data;
      CELL_LOAD:       data <= key;
      CELL_FROM_LEFT:  data <= left;
      CELL_FROM_RIGHT: data <= right;
      CELL_FROM_HEAD:  data <= head;
      default:         data <= data;
    endcase
  end

endmodule

// ===== rtl/bounded_list_deque_delete_by_value.sv =====
// ----------------------------------------------------------------------------
// bounded_list_deque_delete_by_value
// Bounded deque held in a chain of cells, with delete by value and dump.
// ----------------------------------------------------------------------------
// timing: a result is registered in the cycle after its request is accepted;
//   a dump first enters the dump state, which then registers its entries
// throughput: one request per cycle when the output is free; a dump holds off requests
//   until done, streaming one entry per cycle while free by rotating the chain
// reset: synchronous, clears fill count, dump state and output valid;
//   cell contents are left as they are
module bounded_list_deque_delete_by_value (
  input logic clk,
  input logic rst,
  bld_req_if.sink   req,
  bld_rsp_if.source rsp
);
  import bld_pkg::*;

  len_t       fill;
  len_t       fill_next;
  len_t       dump_idx;
  logic       dumping;
  logic       slot_free;
  logic       fire;
  logic       emit;
  logic       dump_last;
  logic       full;
  logic       empty;
  status_t    st;
  action_t    act;
  data_t      key;
  data_t      cell_data [DEPTH];
  logic       seen      [DEPTH];
  cell_ctrl_t ctrl      [DEPTH];

  assign slot_free = !rsp.valid || rsp.ready;
  assign req.ready = !dumping && slot_free;
  assign fire      = req.valid && req.ready;
  assign emit      = dumping && slot_free;
  assign dump_last = (dump_idx == fill - len_t'(1));
  assign full      = (fill == len_t'(DEPTH));
  assign empty     = (fill == '0);
  assign act       = action_t'(req.action);
  assign key       = req.value[DATA_WIDTH-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bld_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl[i]),
      .key      (key),
      .left     ((i == 0) ? cell_data[0] : cell_data[(i == 0) ? 0 : i - 1]),
      .right    (cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .head     (cell_data[0]),
      .seen_in  ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i - 1]),
      .data     (cell_data[i]),
      .seen_out (seen[i])
    );
  end

  // per-cell command and result status
  always_comb begin
    st        = ST_OK;
    fill_next = fill;
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].op    = CELL_HOLD;
      ctrl[i].valid = (len_t'(i) < fill);
    end
    if (emit) begin
      // rotate the live part of the chain by one
      for (int i = 0; i < DEPTH; i++) begin
        if (len_t'(i) == fill - len_t'(1)) begin
          ctrl[i].op = CELL_FROM_HEAD;
        end else if (len_t'(i) < fill) begin
          ctrl[i].op = CELL_FROM_RIGHT;
        end
      end
    end else if (fire) begin
      unique case (act)
        ACT_INS_FRONT: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            fill_next = fill + len_t'(1);
            for (int i = 0; i < DEPTH; i++) begin
              ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
            end
          end
        end
        ACT_INS_BACK: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            fill_next = fill + len_t'(1);
            for (int i = 0; i < DEPTH; i++) begin
              if (len_t'(i) == fill) ctrl[i].op = CELL_LOAD;
            end
          end
        end
        ACT_REM_FRONT: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            fill_next = fill - len_t'(1);
            for (int i = 0; i < DEPTH - 1; i++) begin
              ctrl[i].op = CELL_FROM_RIGHT;
            end
          end
        end
        ACT_REM_BACK: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            fill_next = fill - len_t'(1);
          end
        end
        ACT_REM_VALUE: begin
          if (empty) begin
            st = ST_EMPTY;
          end else if (!seen[DEPTH-1]) begin
            st = ST_NOTFOUND;
          end else begin
            fill_next = fill - len_t'(1);
            // close the gap from the first match onwards
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (seen[i]) ctrl[i].op = CELL_FROM_RIGHT;
            end
          end
        end
        ACT_DUMP: begin
          if (empty) st = ST_EMPTY;
        end
        default: begin
          st = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      dumping  <= 1'b0;
      dump_idx <= '0;
    end else begin
      fill <= fill_next;
      if (fire && act == ACT_DUMP && !empty) begin
        dumping  <= 1'b1;
        dump_idx <= '0;
      end else if (emit) begin
        dump_idx <= dump_idx + len_t'(1);
        if (dump_last) dumping <= 1'b0;
      end
    end
  end

  // output register, one transaction held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (fire) begin
      rsp.valid <= !(act == ACT_DUMP && !empty);
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.status <= ST_OK;
      rsp.entry  <= 32'(signed'(cell_data[0]));
      rsp.length <= 5'(fill);
      rsp.last   <= dump_last;
    end else if (fire) begin
      rsp.status <= st;
      rsp.entry  <= '0;
      rsp.length <= 5'(fill_next);
      rsp.last   <= 1'b1;
    end
  end

  a_no_accept_in_dump: assert property (@(posedge clk) disable iff (rst)
    dumping |-> !req.ready)
    else $error("request accepted during dump");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= len_t'(DEPTH))
    else $error("fill count beyond depth");

  a_dump_start: assert property (@(posedge clk) disable iff (rst)
    (fire && act == ACT_DUMP && !empty) |=> (dumping && dump_idx == '0 && !rsp.valid))
    else $error("dump did not start");

  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (emit && dump_last) |=> (!dumping && rsp.valid && rsp.last))
    else $error("dump did not end on last entry");

endmodule
